### src/mmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmfs_pkg;

	localparam int FEATURES_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FEATURE_W       = 4;
	localparam int CMD_W           = 2;
	localparam int Q_FRAC_BITS     = 16;
	localparam int SCALED_W        = Q_FRAC_BITS + 1;
	localparam logic [SCALED_W-1:0] Q_ONE = {1'b1, {Q_FRAC_BITS{1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_SCALE   = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

### src/min_max_feature_scaler_top.sv
// per-feature min-max scaler
// input channel: in_valid / in_stall with command, feature_index, value.
//   command observe folds value into the running min and max of its feature,
//   scale returns (value - min) / (max - min) as unsigned Q1.16 (65536 = 1.0),
//   clear restores every feature to the empty state. code 3 is dropped.
// output channel: out_valid / out_stall with out_feature, scaled, raw_value,
//   passed_through. only scale beats produce an output beat. a feature with
//   max <= min (zero range or never observed) or an index out of range
//   returns scaled 0 with passed_through set.
// timing: after an accepted beat in_stall stays high until the item is done.
//   clear acts on acceptance, observe steps through look and prep, scale
//   through look, prep and done, adding divide states when division is needed,
//   run by the restoring divider that yields one quotient bit per cycle. the
//   result sits in an output register; while out_stall holds it there, the
//   next input beat is still taken; a finished scale waits for it to drain.
// reset: all statistics read as empty, no clearing pass, both channels idle.
`timescale 1ns / 1ps
`default_nettype none

module min_max_feature_scaler_top #(
	parameter int FEATURES    = mmfs_pkg::FEATURES_DEF,
	parameter int SAMPLE_BITS = mmfs_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [mmfs_pkg::CMD_W-1:0]     command,
	input  wire logic [mmfs_pkg::FEATURE_W-1:0] feature_index,
	input  wire logic signed [SAMPLE_BITS-1:0]  value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [mmfs_pkg::FEATURE_W-1:0]      out_feature,
	output logic [mmfs_pkg::SCALED_W-1:0]       scaled,
	output logic signed [SAMPLE_BITS-1:0]       raw_value,
	output logic                                passed_through
);
	import mmfs_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int CNT_W = $clog2(Q_FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_FRAC_BITS - 1);
	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	state_t state_q, state_d;

	cmd_t                   cmd_q;
	logic [FEATURE_W-1:0]   feat_q;
	logic signed [SB-1:0]   val_q;
	logic                   in_range_q;
	logic [IDX_W-1:0]       addr_q;

	logic signed [SB-1:0]   min_mem [FEATURES];
	logic signed [SB-1:0]   max_mem [FEATURES];
	logic signed [SB-1:0]   min_rd_q, max_rd_q;
	logic [FEATURES-1:0]    valid_q;
	logic                   ent_valid_q;

	logic [SB-1:0]          rem_q, den_q;
	logic [Q_FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SCALED_W-1:0]    res_scaled_q;
	logic                   res_pass_q;

	logic                   out_valid_q;
	logic [FEATURE_W-1:0]   out_feature_q;
	logic [SCALED_W-1:0]    scaled_q;
	logic signed [SB-1:0]   raw_value_q;
	logic                   passed_through_q;

	logic                   accept;
	logic [8:0]             idx_wide;
	logic signed [SB-1:0]   lo, hi;
	logic                   range_ok;
	logic [SB-1:0]          diff_vl, diff_hl;
	logic [SB:0]            trial;
	logic                   trial_ge;
	logic [SB-1:0]          trial_sub;
	logic [Q_FRAC_BITS-1:0] quo_next;
	logic                   do_write;
	logic                   start_div;
	logic                   load_out;

	assign accept   = in_valid && !in_stall;
	assign idx_wide = 9'(feature_index);

	// statistics seen through the valid bits
	assign lo       = ent_valid_q ? min_rd_q : S_MAX;
	assign hi       = ent_valid_q ? max_rd_q : S_MIN;
	assign range_ok = in_range_q && (hi > lo);
	assign diff_vl  = val_q - lo;
	assign diff_hl  = hi - lo;

	// shared restoring divide step
	assign trial     = {rem_q, 1'b0};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial[SB-1:0] - den_q;
	assign quo_next  = {quo_q[Q_FRAC_BITS-2:0], trial_ge};

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		do_write  = 1'b0;
		start_div = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (command == CMD_OBSERVE || command == CMD_SCALE)) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_PREP;
			end
			S_PREP: begin
				if (cmd_q == CMD_OBSERVE) begin
					do_write = in_range_q;
					state_d  = S_IDLE;
				end else if (range_ok && val_q > lo && val_q < hi) begin
					start_div = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && command == CMD_CLEAR) begin
				valid_q <= '0;
			end else if (do_write) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (start_div) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// statistics memories
	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			min_rd_q    <= min_mem[addr_q];
			max_rd_q    <= max_mem[addr_q];
			ent_valid_q <= valid_q[addr_q];
		end
		if (do_write) begin
			min_mem[addr_q] <= (val_q < lo) ? val_q : lo;
			max_mem[addr_q] <= (val_q > hi) ? val_q : hi;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(command);
			feat_q     <= feature_index;
			val_q      <= value;
			in_range_q <= idx_wide < 9'(FEATURES);
			addr_q     <= idx_wide[IDX_W-1:0];
		end
		if (state_q == S_PREP) begin
			rem_q        <= diff_vl;
			den_q        <= diff_hl;
			quo_q        <= '0;
			res_pass_q   <= !range_ok;
			res_scaled_q <= (range_ok && val_q >= hi) ? Q_ONE : '0;
		end else if (state_q == S_DIV) begin
			rem_q <= trial_ge ? trial_sub : trial[SB-1:0];
			quo_q <= quo_next;
			if (cnt_q == CNT_LAST) begin
				res_scaled_q <= {1'b0, quo_next};
			end
		end
		if (load_out) begin
			out_feature_q    <= feat_q;
			scaled_q         <= res_scaled_q;
			raw_value_q      <= val_q;
			passed_through_q <= res_pass_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_feature    = out_feature_q;
	assign scaled         = scaled_q;
	assign raw_value      = raw_value_q;
	assign passed_through = passed_through_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_CLEAR) |=> (valid_q == '0))
		else $error("clear did not empty the statistics");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_pass_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && passed_through) |-> (scaled == '0))
		else $error("pass-through result with nonzero scaled value");

	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scaled <= Q_ONE))
		else $error("scaled value above one");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
